@@ sv/rrf_pkg.sv @@
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared constants and the command and status bundles of the fusion block.
// ----------------------------------------------------------------------------
package rrf_pkg;

    localparam int DEF_MAX_LIST        = 32;
    localparam int DEF_SCORE_FRAC_BITS = 24;

    localparam int RRF_BASE     = 60;
    localparam int OUT_CAP      = 32;
    localparam int NORM_MUL     = 61;
    localparam int LIMIT_W      = 6;
    localparam int LIMIT_RESET  = 5;
    localparam int ID_W         = 32;
    localparam int SIM_W        = 17;
    localparam int KIND_W       = 2;
    localparam int DIV_W        = 7;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 56;
    localparam int SCORE_ONE    = 65536;

    localparam logic [KIND_W-1:0] KIND_DENSE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KEYWORD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    typedef struct packed {
        logic capture;
        logic set_ovf;
        logic load_start;
        logic scan_step;
        logic resolve;
        logic sc_read;
        logic update;
        logic fin_start;
        logic pt_read;
        logic pt_id;
        logic pt_load;
        logic sel_init;
        logic sel_step;
        logic sel_mark;
        logic sel_norm;
        logic clear;
    } rrf_cmd_t;

    typedef struct packed {
        logic is_load;
        logic is_fin;
        logic full;
        logic hit;
        logic miss;
        logic div_done;
        logic kw_empty;
        logic more;
        logic scan_end;
        logic out_busy;
    } rrf_sts_t;

endpackage

@@ sv/rrf_div.sv @@
// ----------------------------------------------------------------------------
// rrf_div
// Serial restoring divider: round-to-nearest of 2^F / d, one bit a cycle.
// ----------------------------------------------------------------------------
module rrf_div import rrf_pkg::*; #(
    parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIV_W-1:0]         divisor,
    output logic                     done,
    output logic [SCORE_FRAC_BITS:0] quot
);

    localparam int NW = SCORE_FRAC_BITS + 1;
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]    dvd_reg, dvd_next;
    logic [NW-1:0]    quot_reg, quot_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dsr_reg, dsr_next;
    logic [CNW-1:0]   cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    always_comb begin
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial     = {rem_reg, dvd_reg[NW-1]};
        if (start) begin
            dvd_next  = (NW'(1) << SCORE_FRAC_BITS) + NW'(divisor >> 1);
            quot_next = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNW'(NW);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next  = DIV_W'(trial - {1'b0, dsr_reg});
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end else begin
                rem_next  = trial[DIV_W-1:0];
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ sv/rrf_datapath.sv @@
// ----------------------------------------------------------------------------
// rrf_datapath
// Slot tables, list counters, id search, score update, selection and output.
// ----------------------------------------------------------------------------
module rrf_datapath import rrf_pkg::*; #(
    parameter int MAX_LIST        = DEF_MAX_LIST,
    parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rrf_cmd_t              cmd,
    output rrf_sts_t              sts,
    input  logic                  cfg_wr_en,
    input  logic [LIMIT_W-1:0]    cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [KIND_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser
);

    localparam int F    = SCORE_FRAC_BITS;
    localparam int SLOTS = 2 * MAX_LIST;
    localparam int SLW  = $clog2(SLOTS);
    localparam int RKW  = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
    localparam int CW   = $clog2(MAX_LIST + 1);
    localparam int DW   = $clog2(SLOTS + 1);
    localparam int RW   = F + 1;
    localparam int SW   = F + 3;
    localparam int SCW  = SW + 3;
    localparam int MW   = SW + 7;
    localparam int NW   = 8;
    localparam int RNDW = 6;
    localparam logic [MW-1:0] RND = MW'(1) << (F - 16);

    logic [ID_W-1:0]  id_mem  [SLOTS];
    logic [SCW-1:0]   sc_mem  [SLOTS];
    logic [SIM_W-1:0] sim_mem [MAX_LIST];
    logic [SLW-1:0]   rs_mem  [MAX_LIST];

    logic [ID_W-1:0]  id_q;
    logic [SCW-1:0]   sc_q;
    logic [SIM_W-1:0] sim_q;
    logic [SLW-1:0]   rs_q;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]      dense_reg, kw_reg;
    logic [DW-1:0]      distinct_reg;
    logic               ovf_reg, drop_reg;
    logic [KIND_W-1:0]  kind_reg;
    logic [ID_W-1:0]    id_in_reg;
    logic [SIM_W-1:0]   sim_in_reg;
    logic [DW-1:0]      scan_reg;
    logic               cmp_vld_reg;
    logic [SLW-1:0]     cmp_idx_reg;
    logic [SLW-1:0]     slot_reg;
    logic               new_reg;
    logic [RNDW-1:0]    round_reg;
    logic [RNDW-1:0]    n_reg;
    logic               have_reg;
    logic [SW-1:0]      best_tot_reg;
    logic [SLW-1:0]     best_idx_reg;
    logic [SCW-1:0]     best_word_reg;
    logic [MW-1:0]      mul_reg;
    logic               out_vld_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [SIM_W-1:0]   out_sc_reg;
    logic               out_last_reg, out_drop_reg;

    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_d;
    logic [RW-1:0]      recip;

    logic               id_rd_en, sc_rd_en;
    logic [SLW-1:0]     id_rd_addr, sc_rd_addr;
    logic               sc_wr_en;
    logic [SLW-1:0]     sc_wr_addr;
    logic [SCW-1:0]     sc_wr_data, upd_word;
    logic [SW-1:0]      tot;
    logic               better;
    logic [NW-1:0]      n_pt, n_fu, lim_w, dist_w;
    logic [MW-1:0]      nv;
    logic               is_dense;

    assign is_dense = (kind_reg == KIND_DENSE);

    rrf_div #(.SCORE_FRAC_BITS(F)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (div_d),
        .done    (div_done),
        .quot    (recip)
    );

    assign div_start = cmd.load_start | cmd.fin_start;
    always_comb begin
        if (cmd.fin_start) begin
            div_d = DIV_W'(RRF_BASE + 1) + DIV_W'(limit_reg);
        end else if (is_dense) begin
            div_d = DIV_W'(RRF_BASE + 1) + DIV_W'(dense_reg);
        end else begin
            div_d = DIV_W'(RRF_BASE + 1) + DIV_W'(kw_reg);
        end
    end

    // memory ports
    always_comb begin
        id_rd_en   = cmd.scan_step | cmd.pt_id | cmd.sel_mark;
        id_rd_addr = scan_reg[SLW-1:0];
        if (cmd.pt_id) begin
            id_rd_addr = rs_q;
        end else if (cmd.sel_mark) begin
            id_rd_addr = best_idx_reg;
        end
        sc_rd_en   = cmd.sc_read | cmd.sel_step;
        sc_rd_addr = cmd.sc_read ? slot_reg : scan_reg[SLW-1:0];
    end

    always_comb begin
        if (new_reg) begin
            upd_word = {1'b0, ~is_dense, is_dense, SW'(recip)};
        end else begin
            upd_word = {1'b0, sc_q[SW+1] | ~is_dense, sc_q[SW] | is_dense,
                        SW'(sc_q[SW-1:0] + SW'(recip))};
        end
        sc_wr_en   = cmd.update | cmd.sel_mark;
        sc_wr_addr = cmd.sel_mark ? best_idx_reg : slot_reg;
        sc_wr_data = cmd.sel_mark ? {1'b1, best_word_reg[SCW-2:0]} : upd_word;
    end

    always_ff @(posedge aclk) begin
        if (id_rd_en) begin
            id_q <= id_mem[id_rd_addr];
        end
        if (sc_rd_en) begin
            sc_q <= sc_mem[sc_rd_addr];
        end
        if (cmd.pt_read) begin
            rs_q  <= rs_mem[round_reg[RKW-1:0]];
            sim_q <= sim_mem[round_reg[RKW-1:0]];
        end
        if (cmd.update && new_reg) begin
            id_mem[slot_reg] <= id_in_reg;
        end
        if (sc_wr_en) begin
            sc_mem[sc_wr_addr] <= sc_wr_data;
        end
        if (cmd.update && is_dense) begin
            rs_mem[dense_reg[RKW-1:0]]  <= slot_reg;
            sim_mem[dense_reg[RKW-1:0]] <= sim_in_reg;
        end
    end

    // selection
    always_comb begin
        tot = sc_q[SW-1:0];
        if (!sc_q[SW]) begin
            tot = SW'(tot + SW'(recip));
        end
        if (!sc_q[SW+1]) begin
            tot = SW'(tot + SW'(recip));
        end
        better = cmp_vld_reg && !sc_q[SW+2] && (!have_reg || tot > best_tot_reg);
    end

    always_comb begin
        lim_w  = NW'(limit_reg);
        dist_w = NW'(distinct_reg);
        n_pt   = (NW'(dense_reg) < NW'(OUT_CAP)) ? NW'(dense_reg) : NW'(OUT_CAP);
        n_fu   = (lim_w < dist_w) ? lim_w : dist_w;
        if (n_fu > NW'(OUT_CAP)) begin
            n_fu = NW'(OUT_CAP);
        end
        nv = (mul_reg + RND) >> (F - 15);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= LIMIT_W'(LIMIT_RESET);
            dense_reg    <= '0;
            kw_reg       <= '0;
            distinct_reg <= '0;
            ovf_reg      <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
            have_reg     <= 1'b0;
            round_reg    <= '0;
            n_reg        <= '0;
            scan_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.load_start || cmd.sel_init) begin
                scan_reg    <= '0;
                cmp_vld_reg <= 1'b0;
                have_reg    <= 1'b0;
            end else if (cmd.scan_step || cmd.sel_step) begin
                cmp_vld_reg <= (scan_reg < distinct_reg);
                cmp_idx_reg <= scan_reg[SLW-1:0];
                if (scan_reg < distinct_reg) begin
                    scan_reg <= scan_reg + DW'(1);
                end
            end
            if (cmd.sel_step && better) begin
                have_reg      <= 1'b1;
                best_tot_reg  <= tot;
                best_idx_reg  <= cmp_idx_reg;
                best_word_reg <= sc_q;
            end
            if (cmd.resolve) begin
                new_reg  <= !sts.hit;
                slot_reg <= sts.hit ? cmp_idx_reg : distinct_reg[SLW-1:0];
            end
            if (cmd.update) begin
                if (new_reg) begin
                    distinct_reg <= distinct_reg + DW'(1);
                end
                if (is_dense) begin
                    dense_reg <= dense_reg + CW'(1);
                end else begin
                    kw_reg <= kw_reg + CW'(1);
                end
            end
            if (cmd.fin_start) begin
                drop_reg  <= ovf_reg;
                round_reg <= '0;
                n_reg     <= (kw_reg == '0) ? RNDW'(n_pt) : RNDW'(n_fu);
            end
            if (cmd.sel_mark) begin
                mul_reg <= MW'(best_tot_reg) * MW'(NORM_MUL);
            end
            if (cmd.pt_load || cmd.sel_norm) begin
                out_vld_reg  <= 1'b1;
                out_last_reg <= (RNDW'(round_reg + RNDW'(1)) == n_reg);
                out_drop_reg <= drop_reg;
                out_id_reg   <= id_q;
                round_reg    <= round_reg + RNDW'(1);
                if (cmd.pt_load) begin
                    out_sc_reg <= sim_q;
                end else if (nv > MW'(SCORE_ONE)) begin
                    out_sc_reg <= SIM_W'(SCORE_ONE);
                end else begin
                    out_sc_reg <= nv[SIM_W-1:0];
                end
            end else if (out_vld_reg && m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (cmd.clear) begin
                dense_reg    <= '0;
                kw_reg       <= '0;
                distinct_reg <= '0;
                ovf_reg      <= 1'b0;
            end
        end
        if (cmd.capture) begin
            kind_reg   <= s_tuser;
            id_in_reg  <= s_tdata[ID_W-1:0];
            sim_in_reg <= s_tdata[ID_W+SIM_W-1:ID_W];
        end
    end

    always_comb begin
        sts.is_load  = (kind_reg == KIND_DENSE) || (kind_reg == KIND_KEYWORD);
        sts.is_fin   = (kind_reg == KIND_FINISH);
        sts.full     = is_dense ? (dense_reg >= CW'(MAX_LIST)) : (kw_reg >= CW'(MAX_LIST));
        sts.hit      = cmp_vld_reg && (id_q == id_in_reg);
        sts.miss     = !cmp_vld_reg && (scan_reg >= distinct_reg);
        sts.scan_end = sts.miss;
        sts.div_done = div_done;
        sts.kw_empty = (kw_reg == '0);
        sts.more     = (round_reg < n_reg);
        sts.out_busy = out_vld_reg;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W - ID_W - SIM_W){1'b0}}, out_sc_reg, out_id_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_drop_reg;

endmodule

@@ sv/rrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrf_ctrl
// Sequencer for loading, id search, score update, passthrough and selection.
// ----------------------------------------------------------------------------
module rrf_ctrl import rrf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  rrf_sts_t sts,
    output rrf_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_SRCH   = 4'd2;
    localparam logic [3:0] ST_RD     = 4'd3;
    localparam logic [3:0] ST_UPD    = 4'd4;
    localparam logic [3:0] ST_PT_RD  = 4'd5;
    localparam logic [3:0] ST_PT_ID  = 4'd6;
    localparam logic [3:0] ST_PT_OUT = 4'd7;
    localparam logic [3:0] ST_PT_WT  = 4'd8;
    localparam logic [3:0] ST_F_DIV  = 4'd9;
    localparam logic [3:0] ST_F_SCAN = 4'd10;
    localparam logic [3:0] ST_F_MARK = 4'd11;
    localparam logic [3:0] ST_F_NORM = 4'd12;
    localparam logic [3:0] ST_F_WT   = 4'd13;
    localparam logic [3:0] ST_CLEAR  = 4'd14;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (sts.is_load) begin
                    if (sts.full) begin
                        cmd.set_ovf = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        cmd.load_start = 1'b1;
                        state_next     = ST_SRCH;
                    end
                end else if (sts.is_fin) begin
                    cmd.fin_start = 1'b1;
                    state_next    = sts.kw_empty ? ST_PT_RD : ST_F_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SRCH: begin
                cmd.scan_step = 1'b1;
                if (sts.hit || sts.miss) begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_RD: begin
                cmd.sc_read = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                if (sts.div_done) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PT_RD: begin
                if (sts.more) begin
                    cmd.pt_read = 1'b1;
                    state_next  = ST_PT_ID;
                end else begin
                    state_next = ST_CLEAR;
                end
            end
            ST_PT_ID: begin
                cmd.pt_id  = 1'b1;
                state_next = ST_PT_OUT;
            end
            ST_PT_OUT: begin
                if (!sts.out_busy) begin
                    cmd.pt_load = 1'b1;
                    state_next  = ST_PT_WT;
                end
            end
            ST_PT_WT: begin
                state_next = ST_PT_RD;
            end
            ST_F_DIV: begin
                if (sts.div_done) begin
                    if (sts.more) begin
                        cmd.sel_init = 1'b1;
                        state_next   = ST_F_SCAN;
                    end else begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_F_SCAN: begin
                cmd.sel_step = 1'b1;
                if (sts.scan_end) begin
                    state_next = ST_F_MARK;
                end
            end
            ST_F_MARK: begin
                cmd.sel_mark = 1'b1;
                state_next   = ST_F_NORM;
            end
            ST_F_NORM: begin
                if (!sts.out_busy) begin
                    cmd.sel_norm = 1'b1;
                    state_next   = ST_F_WT;
                end
            end
            ST_F_WT: begin
                state_next = ST_F_DIV;
            end
            ST_CLEAR: begin
                if (!sts.out_busy) begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ sv/reciprocal_rank_fusion.sv @@
// ----------------------------------------------------------------------------
// reciprocal_rank_fusion
// Rank fusion of a dense and a keyword list with k = 60 and top-k output.
// ----------------------------------------------------------------------------
// A list item takes one search pass over the stored distinct ids and waits
// for the serial reciprocal divider, whichever is longer; the searches and
// the divider run side by side. A finish item first runs the divider once,
// then selects each result with one pass over the stored ids, or in
// passthrough gives the dense list's results in rank order. Input is taken
// only when the block is idle.
module reciprocal_rank_fusion import rrf_pkg::*; #(
    parameter int MAX_LIST        = DEF_MAX_LIST,
    parameter int SCORE_FRAC_BITS = DEF_SCORE_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [LIMIT_W-1:0]    cfg_wr_data,  // result_limit
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,      // entry_id, dense_similarity
    input  logic [KIND_W-1:0]     s_tuser,      // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,      // result_id, fused_score
    output logic                  m_tlast,
    output logic                  m_tuser       // dropped
);

    rrf_cmd_t cmd;
    rrf_sts_t sts;

    rrf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrf_datapath #(
        .MAX_LIST        (MAX_LIST),
        .SCORE_FRAC_BITS (SCORE_FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

@@ sim/reciprocal_rank_fusion_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reciprocal_rank_fusion_test
// Self-checking bench for the rank fusion block: dense and keyword lists are
// loaded with random gaps, each finish is predicted in the bench and every
// result item is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module reciprocal_rank_fusion_test;
    import rrf_pkg::*;

    localparam int LIST_CAP  = 32;
    localparam int FRAC      = 24;
    localparam int SLOTS     = 2 * LIST_CAP;
    localparam int MAX_CYCLE = 2000000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [SIM_W-1:0]  sim;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SIM_W-1:0] score;
        logic             last;
        logic             dropped;
    } fused_t;

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  cfg_wr_en = 0;
    logic [LIMIT_W-1:0]    cfg_wr_data = '0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    reciprocal_rank_fusion dut (.*);

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // predictor state
    logic [ID_W-1:0]  slot_id [SLOTS];
    logic [63:0]      slot_score [SLOTS];
    logic             slot_dense [SLOTS];
    logic             slot_kw [SLOTS];
    logic [SIM_W-1:0] rank_sim [LIST_CAP];
    int               rank_slot [LIST_CAP];
    int               n_dense, n_kw, n_distinct;
    logic             overflow;
    int               limit = LIMIT_RESET;

    entry_t pending_items[$];
    fused_t fused_expected[$];
    int     failures = 0;
    int     cycle = 0;

    function automatic logic [63:0] recip(int d);
        return ((64'd1 << FRAC) + d / 2) / d;
    endfunction

    function automatic logic [SIM_W-1:0] normalise(logic [63:0] s);
        logic [63:0] v;
        v = (s * 61 + (64'd1 << (FRAC - 16))) >> (FRAC - 15);
        return v > SCORE_ONE ? SIM_W'(SCORE_ONE) : v[SIM_W-1:0];
    endfunction

    task automatic clear_lists();
        n_dense = 0;
        n_kw = 0;
        n_distinct = 0;
        overflow = 0;
    endtask

    task automatic fuse_item(entry_t e);
        int s, n, best, k;
        logic [63:0] total [SLOTS];
        bit taken [SLOTS];
        logic [63:0] miss;
        fused_t r;
        if (e.kind == KIND_DENSE || e.kind == KIND_KEYWORD) begin
            n = (e.kind == KIND_DENSE) ? n_dense : n_kw;
            if (n >= LIST_CAP) begin
                overflow = 1;
                return;
            end
            s = n_distinct;
            for (int i = 0; i < n_distinct; i++)
                if (slot_id[i] == e.id) begin
                    s = i;
                    break;
                end
            if (s == n_distinct) begin
                slot_id[s] = e.id;
                slot_score[s] = 0;
                slot_dense[s] = 0;
                slot_kw[s] = 0;
                n_distinct++;
            end
            slot_score[s] += recip(RRF_BASE + n + 1);
            if (e.kind == KIND_DENSE) begin
                slot_dense[s] = 1;
                rank_slot[n] = s;
                rank_sim[n] = e.sim;
                n_dense++;
            end else begin
                slot_kw[s] = 1;
                n_kw++;
            end
            return;
        end
        if (e.kind != KIND_FINISH)
            return;
        if (n_kw == 0) begin
            n = n_dense;
            for (s = 0; s < n; s++) begin
                r.id = slot_id[rank_slot[s]];
                r.score = rank_sim[s];
                r.last = (s + 1 == n);
                r.dropped = overflow;
                fused_expected.insert(fused_expected.size(), r);
            end
        end else begin
            miss = recip(RRF_BASE + limit + 1);
            for (s = 0; s < n_distinct; s++) begin
                total[s] = slot_score[s] + (slot_dense[s] ? 0 : miss) + (slot_kw[s] ? 0 : miss);
                taken[s] = 0;
            end
            n = limit;
            if (n > n_distinct) n = n_distinct;
            if (n > OUT_CAP) n = OUT_CAP;
            for (k = 0; k < n; k++) begin
                best = -1;
                for (s = 0; s < n_distinct; s++)
                    if (!taken[s] && (best < 0 || total[s] > total[best]))
                        best = s;
                taken[best] = 1;
                r.id = slot_id[best];
                r.score = normalise(total[best]);
                r.last = (k + 1 == n);
                r.dropped = overflow;
                fused_expected.insert(fused_expected.size(), r);
            end
        end
        clear_lists();
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input handshake seen at the rising edge
    bit in_taken = 0;
    always @(posedge aclk) begin
        in_taken = aresetn && s_tvalid && s_tready;
    end

    // driver
    int     in_gap = 0;
    entry_t cur;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                fuse_item(cur);
                void'(pending_items.pop_front());
                in_gap = gap_len();
            end
            if (s_tvalid && !in_taken) begin
            end else if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 0;
            end else if (pending_items.size() > 0) begin
                cur = pending_items[0];
                s_tvalid <= 1;
                s_tuser <= cur.kind;
                s_tdata <= {7'd0, cur.sim, cur.id};
            end else begin
                s_tvalid <= 0;
            end
        end
    end

    // monitor
    int out_gap = 0;
    always @(posedge aclk) begin
        fused_t got, exp_r;
        cycle <= cycle + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.id = m_tdata[ID_W-1:0];
            got.score = m_tdata[ID_W+SIM_W-1:ID_W];
            got.last = m_tlast;
            got.dropped = m_tuser;
            if (fused_expected.size() == 0) begin
                $display("%0t: unexpected result id %h score %0d", $time, got.id, got.score);
                failures++;
            end else begin
                exp_r = fused_expected.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: mismatch expected id %h score %0d last %b drop %b",
                             $time, exp_r.id, exp_r.score, exp_r.last, exp_r.dropped);
                    $display("%0t:           actual id %h score %0d last %b drop %b",
                             $time, got.id, got.score, got.last, got.dropped);
                    failures++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (out_gap > 0) begin
            out_gap--;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            if ($urandom_range(0, 9) < 3) out_gap = gap_len();
        end
    end

    always @(posedge aclk) begin
        if (cycle > MAX_CYCLE) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic add(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic [SIM_W-1:0] sim);
        entry_t e;
        e.kind = k;
        e.id = id;
        e.sim = sim;
        pending_items.insert(pending_items.size(), e);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || fused_expected.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_limit(int v);
        @(negedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= LIMIT_W'(v);
        @(negedge aclk);
        cfg_wr_en <= 0;
        limit = v;
    endtask

    // a random round: shared id pool so that ids overlap between lists
    task automatic random_round(int nd, int nk);
        logic [ID_W-1:0] pool [8];
        int id_total;
        foreach (pool[i]) pool[i] = $urandom;
        id_total = nd + nk;
        for (int i = 0; i < id_total; i++) begin
            logic [KIND_W-1:0] k;
            logic [ID_W-1:0] id;
            k = (i < nd) ? KIND_DENSE : KIND_KEYWORD;
            if (nd > 0 && nk > 0 && i >= nd && $urandom_range(0, 1)) k = KIND_DENSE;
            id = $urandom_range(0, 2) ? pool[$urandom_range(0, 7)] : $urandom;
            if ($urandom_range(0, 30) == 0) k = KIND_UNUSED;
            add(k, id, $urandom_range(0, 1) ? SIM_W'($urandom_range(0, SCORE_ONE))
                                            : SIM_W'($urandom_range(0, 17'h1FFFF)));
        end
        add(KIND_FINISH, $urandom, SIM_W'($urandom));
    endtask

    initial begin
        clear_lists();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: passthrough with extremes, unused kind, empty finish
        add(KIND_DENSE, 32'hFFFFFFFF, 17'h1FFFF);
        add(KIND_DENSE, 32'h0, 17'h0);
        add(KIND_DENSE, 32'hFFFFFFFF, SIM_W'(SCORE_ONE));
        add(KIND_UNUSED, 32'h12345678, 17'h1FFFF);
        add(KIND_FINISH, '0, '0);
        add(KIND_FINISH, 32'hFFFFFFFF, 17'h1FFFF);
        // fusion at reset limit with repeated ids
        add(KIND_DENSE, 32'hA, SIM_W'(100));
        add(KIND_DENSE, 32'hB, SIM_W'(200));
        add(KIND_KEYWORD, 32'hB, '0);
        add(KIND_KEYWORD, 32'hA, '0);
        add(KIND_KEYWORD, 32'hA, '0);
        add(KIND_KEYWORD, 32'hC, '0);
        add(KIND_FINISH, '0, '0);
        drain();

        // list full on both lists
        set_limit(32);
        for (int i = 0; i < 34; i++) add(KIND_DENSE, ID_W'(i), SIM_W'(i));
        for (int i = 0; i < 34; i++) add(KIND_KEYWORD, ID_W'(100 + i), '0);
        add(KIND_FINISH, '0, '0);
        for (int i = 0; i < 33; i++) add(KIND_DENSE, $urandom, SIM_W'($urandom));
        add(KIND_FINISH, '0, '0);
        drain();

        set_limit(0);
        add(KIND_DENSE, ID_W'(1), SIM_W'(1));
        add(KIND_KEYWORD, ID_W'(2), '0);
        add(KIND_FINISH, '0, '0);
        drain();

        set_limit(63);
        random_round(20, 20);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            set_limit(ph == 0 ? 1 : $urandom_range(1, 12));
            for (int r = 0; r < 3; r++)
                random_round($urandom_range(0, 8), $urandom_range(0, 6));
            drain();
        end
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
